// ----- design/cbji_pkg.sv -----
`timescale 1ns / 1ps
// cbji_pkg: shared types, constants and the blend table function of the
// cosine blend joint interpolator; used by cbji_ctrl, cbji_dpath and the top level

package cbji_pkg;

	localparam int FIELD_JOINTS = 7;
	localparam int IN_W         = 136;
	localparam int OUT_W        = 120;
	localparam int REG_IDX_W    = 3;
	localparam int CFG_W        = 32;

	// register indexes of the configuration port
	localparam logic [REG_IDX_W-1:0] REG_GOAL_J1  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_J2  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_J3  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_J4  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_J5  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_J6  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_J7  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DURATION = 3'd7;

	// input tdata layout
	localparam int IN_PERIOD_LSB = 0;
	localparam int IN_BEGIN_BIT  = 16;
	localparam int IN_REF_LSB    = 17;

	// output tdata layout
	localparam int OUT_FIN_BIT   = 112;
	localparam int OUT_FAULT_BIT = 113;
	localparam int OUT_FJ_LSB    = 114;

	localparam logic [31:0] DURATION_RESET = 32'd4000000;
	localparam logic signed [15:0] GOAL_RESET [FIELD_JOINTS] = '{
		16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd8192, 16'sd0
	};

	// joint limits, Q3.13
	localparam logic signed [15:0] LIM_MIN [8] = '{
		-16'sd23734, -16'sd14440, -16'sd23734, -16'sd25164,
		-16'sd23734, -16'sd143, -16'sd23734, -16'sd32768
	};
	localparam logic signed [15:0] LIM_MAX [8] = '{
		16'sd23734, 16'sd14440, 16'sd23734, -16'sd572,
		16'sd23734, 16'sd30740, 16'sd23734, 16'sd32767
	};

	localparam logic [16:0] BLEND_ONE = 17'h10000;
	localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60   = 64'h1000000000000000;

	typedef struct packed {
		logic capture;
		logic update;
		logic prep;
		logic div_step;
		logic rom_rd;
		logic mul;
		logic acc;
		logic out_load;
	} cbji_cmd_t;

	typedef struct packed {
		logic fault;
		logic done;
		logic div_last;
		logic joint_last;
		logic out_free;
	} cbji_sts_t;

	// (a * b) >> 60, truncated to 64 bits
	function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// table entry: round(65536 * (0.5 - 0.5 cos(pi * idx / 2^bits))), taylor series at Q60
	function automatic logic [16:0] blend_entry(input int unsigned idx, input int unsigned bits);
		logic [63:0] ts;
		logic [63:0] j;
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] b60;
		logic        flip;
		ts    = 64'd1 << bits;
		flip  = ({32'd0, idx} << 1) > ts;
		j     = flip ? ts - {32'd0, idx} : {32'd0, idx};
		theta = (PI_Q60 >> bits) * j;
		x2    = mul_q(theta, theta);
		term  = ONE_Q60;
		sum   = term;
		term  = mul_q(term, x2) / 64'd2;   sum = sum - term;
		term  = mul_q(term, x2) / 64'd12;  sum = sum + term;
		term  = mul_q(term, x2) / 64'd30;  sum = sum - term;
		term  = mul_q(term, x2) / 64'd56;  sum = sum + term;
		term  = mul_q(term, x2) / 64'd90;  sum = sum - term;
		term  = mul_q(term, x2) / 64'd132; sum = sum + term;
		term  = mul_q(term, x2) / 64'd182; sum = sum - term;
		term  = mul_q(term, x2) / 64'd240; sum = sum + term;
		term  = mul_q(term, x2) / 64'd306; sum = sum - term;
		term  = mul_q(term, x2) / 64'd380; sum = sum + term;
		term  = mul_q(term, x2) / 64'd462; sum = sum - term;
		term  = mul_q(term, x2) / 64'd552; sum = sum + term;
		b60   = flip ? (64'd1 << 59) + (sum >> 1) : (64'd1 << 59) - (sum >> 1);
		b60   = b60 + (64'd1 << 43);
		return b60[60:44];
	endfunction

endpackage

// ----- design/cbji_ctrl.sv -----
`timescale 1ns / 1ps
// cbji_ctrl: sequencer of the interpolator, one tick at a time
// depends on cbji_pkg for the command and status structs

module cbji_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cbji_pkg::cbji_sts_t sts,
	output cbji_pkg::cbji_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_ROM  = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.fault) state_d = ST_OUT;
				else if (sts.done) state_d = ST_MUL;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_ROM;
			end
			ST_ROM: begin
				cmd.rom_rd = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.joint_last ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/cbji_dpath.sv -----
`timescale 1ns / 1ps
// cbji_dpath: configuration registers, motion state, shift-subtract divider,
// blend table, shared multiplier and output register; depends on cbji_pkg

module cbji_dpath #(
	parameter int NUM_JOINTS       = 7,
	parameter int BLEND_TABLE_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [cbji_pkg::REG_IDX_W-1:0]    cfg_addr,
	input  logic [cbji_pkg::CFG_W-1:0]        cfg_data,
	input  logic [cbji_pkg::IN_W-1:0]         in_data,
	output logic [cbji_pkg::OUT_W-1:0]        out_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	input  cbji_pkg::cbji_cmd_t               cmd,
	output cbji_pkg::cbji_sts_t               sts
);

	localparam int FJ = cbji_pkg::FIELD_JOINTS;
	localparam int JU = (NUM_JOINTS < FJ) ? NUM_JOINTS : FJ;
	localparam int JW = (JU > 1) ? $clog2(JU) : 1;
	localparam int TB = BLEND_TABLE_BITS;
	localparam int TS = 1 << TB;
	localparam int CW = $clog2(TB);

	logic signed [15:0] goal_q [FJ];
	logic [31:0]        dur_q;

	logic [15:0]        period_q;
	logic               begin_q;
	logic signed [15:0] ref_q   [JU];
	logic signed [15:0] start_q [JU];
	logic signed [15:0] cmd_q   [JU];

	logic        armed_q;
	logic        fault_q;
	logic [2:0]  fidx_q;
	logic [31:0] elapsed_q;

	logic [31:0]   rem_q;
	logic [TB-1:0] quo_q;
	logic [CW-1:0] dcnt_q;
	logic [16:0]   blend_q;
	logic [JW-1:0] jidx_q;
	logic signed [34:0] prod_s1;

	logic [cbji_pkg::OUT_W-1:0] odata_q;
	logic                       ovalid_q;

	logic [16:0] blend_rom [TS];

	// limit check and elapsed time
	logic [JU-1:0] bad;
	logic          any_bad;
	logic [2:0]    first_bad;
	logic [32:0]   esum;
	logic [31:0]   eacc;
	logic [31:0]   ecap;
	logic [32:0]   rem_sh;
	logic          rem_ge;
	logic signed [16:0] diff;
	logic signed [35:0] rnd;
	logic [cbji_pkg::OUT_W-1:0] odata_d;

	for (genvar g = 0; g < TS; g++) begin : g_rom
		assign blend_rom[g] = cbji_pkg::blend_entry(g, TB);
	end

	always_comb begin
		first_bad = 3'd0;
		for (int j = 0; j < JU; j++) begin
			bad[j] = (goal_q[j] < cbji_pkg::LIM_MIN[j]) || (goal_q[j] > cbji_pkg::LIM_MAX[j]);
		end
		for (int j = JU - 1; j >= 0; j--) begin
			if (bad[j]) first_bad = 3'(j);
		end
		any_bad = |bad;
	end

	assign esum   = {1'b0, elapsed_q} + {17'd0, period_q};
	assign eacc   = (esum < {1'b0, dur_q}) ? esum[31:0] : dur_q;
	assign ecap   = ({16'd0, period_q} < dur_q) ? {16'd0, period_q} : dur_q;
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, dur_q});
	assign diff   = 17'(goal_q[jidx_q]) - 17'(start_q[jidx_q]);
	assign rnd    = 36'(prod_s1) + 36'sd32768;

	assign sts.fault      = fault_q;
	assign sts.done       = (elapsed_q >= dur_q);
	assign sts.div_last   = (dcnt_q == CW'(TB - 1));
	assign sts.joint_last = (jidx_q == JW'(JU - 1));
	assign sts.out_free   = !ovalid_q || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FJ; j++) goal_q[j] <= cbji_pkg::GOAL_RESET[j];
			dur_q <= cbji_pkg::DURATION_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				cbji_pkg::REG_DURATION: dur_q <= cfg_data;
				default: goal_q[cfg_addr] <= cfg_data[15:0];
			endcase
		end
	end

	// motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			fault_q   <= 1'b0;
			fidx_q    <= 3'd0;
			elapsed_q <= 32'd0;
		end else if (cmd.update) begin
			if (begin_q || !armed_q) begin
				armed_q   <= 1'b1;
				fault_q   <= any_bad;
				fidx_q    <= any_bad ? first_bad : 3'd0;
				elapsed_q <= any_bad ? 32'd0 : ecap;
			end else if (!fault_q) begin
				elapsed_q <= eacc;
			end
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			period_q <= in_data[cbji_pkg::IN_PERIOD_LSB +: 16];
			begin_q  <= in_data[cbji_pkg::IN_BEGIN_BIT];
			for (int j = 0; j < JU; j++) ref_q[j] <= in_data[cbji_pkg::IN_REF_LSB + 16 * j +: 16];
		end
		if (cmd.update && (begin_q || !armed_q)) begin
			for (int j = 0; j < JU; j++) start_q[j] <= ref_q[j];
		end
		if (cmd.prep) begin
			rem_q   <= elapsed_q;
			quo_q   <= '0;
			dcnt_q  <= '0;
			jidx_q  <= '0;
			blend_q <= cbji_pkg::BLEND_ONE;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? 32'(rem_sh - {1'b0, dur_q}) : rem_sh[31:0];
			quo_q  <= {quo_q[TB-2:0], rem_ge};
			dcnt_q <= dcnt_q + CW'(1);
		end
		if (cmd.rom_rd) begin
			blend_q <= blend_rom[quo_q];
		end
		if (cmd.mul) begin
			prod_s1 <= $signed({1'b0, blend_q}) * diff;
		end
		if (cmd.acc) begin
			cmd_q[jidx_q] <= start_q[jidx_q] + rnd[31:16];
			jidx_q        <= jidx_q + JW'(1);
		end
		if (cmd.out_load) begin
			odata_q <= odata_d;
		end
	end

	// result packing; joints beyond the configured count read zero
	for (genvar g = 0; g < FJ; g++) begin : g_pack
		if (g < JU) begin : g_used
			assign odata_d[16 * g +: 16] = fault_q ? start_q[g] : cmd_q[g];
		end else begin : g_zero
			assign odata_d[16 * g +: 16] = 16'd0;
		end
	end
	assign odata_d[cbji_pkg::OUT_FIN_BIT]      = fault_q || (elapsed_q >= dur_q);
	assign odata_d[cbji_pkg::OUT_FAULT_BIT]    = fault_q;
	assign odata_d[cbji_pkg::OUT_FJ_LSB +: 3]  = fidx_q;
	assign odata_d[cbji_pkg::OUT_W-1:cbji_pkg::OUT_FJ_LSB+3] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign out_data  = odata_q;
	assign out_valid = ovalid_q;

endmodule

// ----- design/cosine_blend_joint_interpolator_top.sv -----
`timescale 1ns / 1ps
// each tick runs capture, update, prep, divider steps, table read, a multiply and an
// accumulate step per joint, output load; a fault goes from prep to output, a finished
// motion skips divider and table; one tick at a time, paced by the one-bit-per-cycle
// divider and the single multiplier shared by all joints; a new tick is taken while a result waits
// reset: arst_n returns state, goals and duration to their reset values at once;
// no table fill is needed; the interpolator rearms on the first tick after reset

module cosine_blend_joint_interpolator_top #(
	parameter int NUM_JOINTS       = 7,
	parameter int BLEND_TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           cfg_wr_en,
	input  logic [cbji_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [cbji_pkg::CFG_W-1:0]     cfg_data,
	// tick input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// period_us[15:0], begin_req[16], ref_j1..ref_j7 16 bits each from bit 17, zero pad
	input  logic [cbji_pkg::IN_W-1:0]      s_axis_tdata,
	// command output
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// cmd_j1..cmd_j7 16 bits each, finished[112], limit_fault[113],
	// fault_joint[116:114], zero pad
	output logic [cbji_pkg::OUT_W-1:0]     m_axis_tdata
);

	// command and status between sequencer and datapath
	cbji_pkg::cbji_cmd_t cmd;
	cbji_pkg::cbji_sts_t sts;

	cbji_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// divider, blend table, multiplier and the output register live here
	cbji_dpath #(
		.NUM_JOINTS       (NUM_JOINTS),
		.BLEND_TABLE_BITS (BLEND_TABLE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	// one tick at a time: the sequencer leaves idle after every transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("tick taken while the previous one is still in work");

	// a limit fault always ends the motion
	a_fault_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[cbji_pkg::OUT_FAULT_BIT]
			|| m_axis_tdata[cbji_pkg::OUT_FIN_BIT]))
		else $error("limit fault reported without finished");

	// a nonzero joint index only comes with a fault
	a_index_needs_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[cbji_pkg::OUT_FJ_LSB +: 3] != 3'd0)
			|-> m_axis_tdata[cbji_pkg::OUT_FAULT_BIT])
		else $error("fault joint index set without a limit fault");

	// the result register is loaded only when it is free, from the output step of the sequencer
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten before transfer");
`endif

endmodule

// ----- verif/cbji_cmd_checker.sv -----
`timescale 1ns / 1ps
// cbji_cmd_checker: predicts the commanded joint positions of the cosine blend interpolator
// from observed register writes and tick transfers, and compares every command transfer
// depends on cbji_pkg for port widths, register indexes and stream layout

module cbji_cmd_checker import cbji_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	// period_us, begin_req, ref_j1..ref_j7, zero pad
	input  logic [IN_W-1:0]      s_axis_tdata,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// cmd_j1..cmd_j7, finished, limit_fault, fault_joint, zero pad
	input  logic [OUT_W-1:0]     m_axis_tdata,
	output int                   mismatches,
	output int                   cmds_pending
);

	localparam int RAMP_BITS = 10;
	localparam int RAMP_SIZE = 1 << RAMP_BITS;
	localparam logic [63:0] PI_FIX60 = 64'h3243F6A8885A308D;
	localparam logic [31:0] RAMP_FULL = 32'h10000;

	// exact Q3.13 joint bounds
	localparam int JOINT_LO [7] = '{-23734, -14440, -23734, -25164, -23734, -143, -23734};
	localparam int JOINT_HI [7] = '{23734, 14440, 23734, -572, 23734, 30740, 23734};
	localparam logic signed [15:0] GOAL_AT_RESET [7] = '{
		16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd8192, 16'sd0
	};
	localparam logic [31:0] DURATION_AT_RESET = 32'd4000000;

	typedef struct packed {
		logic [2:0]       fault_joint;
		logic             limit_fault;
		logic             finished;
		logic [6:0][15:0] pos;
	} joint_cmd_t;

	logic signed [15:0] goal [7] = GOAL_AT_RESET;
	logic [31:0]        duration = DURATION_AT_RESET;
	logic [31:0]        elapsed = '0;
	logic               armed = 1'b0;
	logic               faulted = 1'b0;
	logic [2:0]         fault_at = '0;
	logic signed [15:0] start_pos [7];
	logic [31:0]        cosine_ramp [RAMP_SIZE];
	joint_cmd_t         cmd_queue [$];
	int                 found;

	// 0.5 - 0.5 cos(pi * step / 2^bits) in Q1.16, taylor series in Q60
	function automatic logic [31:0] ramp_entry(input int unsigned step);
		logic [127:0] wide;
		logic [63:0]  angle;
		logic [63:0]  angle_sq;
		logic [63:0]  term;
		logic [63:0]  series;
		logic [63:0]  half;
		logic         mirror;
		int unsigned  j;
		mirror = (2 * step) > RAMP_SIZE;
		j = mirror ? RAMP_SIZE - step : step;
		angle = (PI_FIX60 >> RAMP_BITS) * 64'(j);
		wide = {64'd0, angle} * {64'd0, angle};
		angle_sq = wide[123:60];
		term = 64'd1 << 60;
		series = term;
		for (int k = 1; k <= 12; k++) begin
			wide = {64'd0, term} * {64'd0, angle_sq};
			term = wide[123:60] / 64'((2 * k - 1) * (2 * k));
			if (k % 2)
				series = series - term;
			else
				series = series + term;
		end
		half = mirror ? (64'd1 << 59) + (series >> 1) : (64'd1 << 59) - (series >> 1);
		half = half + (64'd1 << 43);
		return 32'(half >> 44);
	endfunction

	initial
		for (int i = 0; i < RAMP_SIZE; i++)
			cosine_ramp[i] = ramp_entry(i);

	// advances the motion state by one tick and returns the command it yields
	function automatic joint_cmd_t advance_motion(input logic [IN_W-1:0] word);
		logic [15:0]        period;
		logic [32:0]        sum;
		logic [47:0]        scaled;
		logic [31:0]        ramp;
		logic signed [63:0] diff;
		logic signed [63:0] prod;
		logic signed [63:0] step_q;
		joint_cmd_t         res;
		period = word[IN_PERIOD_LSB +: 16];
		if (word[IN_BEGIN_BIT] || !armed) begin
			armed = 1'b1;
			faulted = 1'b0;
			fault_at = '0;
			for (int j = 0; j < 7; j++)
				start_pos[j] = word[IN_REF_LSB + 16 * j +: 16];
			// scanned downward so the lowest offending joint wins
			for (int j = 6; j >= 0; j--)
				if (goal[j] < JOINT_LO[j] || goal[j] > JOINT_HI[j]) begin
					faulted = 1'b1;
					fault_at = 3'(j);
				end
			if (faulted)
				elapsed = '0;
			else
				elapsed = ({16'd0, period} < duration) ? {16'd0, period} : duration;
		end else if (!faulted) begin
			sum = {1'b0, elapsed} + {17'd0, period};
			elapsed = (sum < {1'b0, duration}) ? sum[31:0] : duration;
		end
		res = '0;
		if (faulted) begin
			for (int j = 0; j < 7; j++)
				res.pos[j] = start_pos[j];
			res.finished = 1'b1;
			res.limit_fault = 1'b1;
			res.fault_joint = fault_at;
		end else begin
			// a zero duration counts as complete, no division
			if (elapsed >= duration)
				ramp = RAMP_FULL;
			else begin
				scaled = {elapsed, 16'd0} / {16'd0, duration};
				ramp = cosine_ramp[scaled[15:6]];
			end
			for (int j = 0; j < 7; j++) begin
				diff = goal[j] - start_pos[j];
				prod = $signed({32'd0, ramp}) * diff;
				step_q = (prod + 64'sd32768) >>> 16;
				res.pos[j] = 16'(start_pos[j] + step_q);
			end
			res.finished = elapsed >= duration;
		end
		return res;
	endfunction

	function automatic int compare_cmd(input joint_cmd_t want, input logic [OUT_W-1:0] got);
		int bad;
		bad = 0;
		for (int j = 0; j < 7; j++)
			if (got[16 * j +: 16] !== want.pos[j]) begin
				$display("%0t ns: cmd_j%0d mismatch, expected %0d, actual %0d", $time, j + 1,
					$signed(want.pos[j]), $signed(got[16 * j +: 16]));
				bad++;
			end
		if (got[OUT_FIN_BIT] !== want.finished) begin
			$display("%0t ns: finished mismatch, expected %0d, actual %0d", $time,
				want.finished, got[OUT_FIN_BIT]);
			bad++;
		end
		if (got[OUT_FAULT_BIT] !== want.limit_fault) begin
			$display("%0t ns: limit_fault mismatch, expected %0d, actual %0d", $time,
				want.limit_fault, got[OUT_FAULT_BIT]);
			bad++;
		end
		if (got[OUT_FJ_LSB +: 3] !== want.fault_joint) begin
			$display("%0t ns: fault_joint mismatch, expected %0d, actual %0d", $time,
				want.fault_joint, got[OUT_FJ_LSB +: 3]);
			bad++;
		end
		return bad;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal = GOAL_AT_RESET;
			duration = DURATION_AT_RESET;
			elapsed = '0;
			armed = 1'b0;
			faulted = 1'b0;
			fault_at = '0;
			cmd_queue.delete();
			mismatches <= 0;
			cmds_pending <= 0;
		end else begin
			found = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (cmd_queue.size() == 0) begin
					$display("%0t ns: command transfer with none expected, actual %h", $time,
						m_axis_tdata);
					found = 1;
				end else
					found = compare_cmd(cmd_queue.pop_front(), m_axis_tdata);
			end
			if (cfg_wr_en) begin
				if (cfg_addr == REG_DURATION)
					duration = cfg_data;
				else
					goal[cfg_addr] = cfg_data[15:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				cmd_queue.push_back(advance_motion(s_axis_tdata));
			mismatches <= mismatches + found;
			cmds_pending <= cmd_queue.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for the cosine blend joint interpolator: ticks, register writes
// and random idling on both stream sides; needs cbji_pkg, the design and cbji_cmd_checker

module tb;
	import cbji_pkg::*;

	localparam int CYCLE_LIMIT     = 600000;
	localparam int TAIL_CYCLES     = 40;
	localparam int RANDOM_PHASES   = 5;
	localparam int TICKS_PER_PHASE = 30;

	typedef logic [FIELD_JOINTS-1:0][15:0] joint_vec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	int mismatches;
	int cmds_pending;

	always #5 clk = ~clk;

	cosine_blend_joint_interpolator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// prediction and comparison live in the checker; the top only reads its mismatch count
	cbji_cmd_checker cmd_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.cmds_pending (cmds_pending)
	);

	// receiver stalls a random share of cycles, one decision per edge
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic joint_vec_t random_refs();
		joint_vec_t v;
		for (int j = 0; j < FIELD_JOINTS; j++)
			v[j] = 16'($urandom);
		return v;
	endfunction

	// alternating most positive and most negative positions
	function automatic joint_vec_t edge_refs(input int phase);
		joint_vec_t v;
		for (int j = 0; j < FIELD_JOINTS; j++)
			v[j] = ((j + phase) % 2) ? 16'h8000 : 16'h7FFF;
		return v;
	endfunction

	// middle of each joint's range, always legal
	function automatic joint_vec_t mid_goals();
		joint_vec_t v;
		for (int j = 0; j < FIELD_JOINTS; j++)
			v[j] = 16'((int'(LIM_MIN[j]) + int'(LIM_MAX[j])) / 2);
		return v;
	endfunction

	// legal goals spread over each range, with a given chance of any 16-bit value
	function automatic joint_vec_t random_goals(input int bad_pct);
		joint_vec_t v;
		int lo;
		int hi;
		for (int j = 0; j < FIELD_JOINTS; j++) begin
			lo = LIM_MIN[j];
			hi = LIM_MAX[j];
			if ($urandom_range(99) < bad_pct)
				v[j] = 16'($urandom);
			else
				v[j] = 16'(lo + int'($urandom_range(hi - lo)));
		end
		return v;
	endfunction

	// mostly a few dozen ticks of mean period, sometimes the extremes
	function automatic logic [31:0] random_duration();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return 32'd1;
		else if (pick < 10)
			return 32'hFFFFFFFF;
		else if (pick < 15)
			return $urandom;
		return $urandom_range(1500000, 20000);
	endfunction

	// one tick transfer; returns at the edge that accepted it with tvalid still high
	task automatic send_tick(input logic [15:0] period, input logic start,
			input joint_vec_t refs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, refs, start, period};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// sender holds off until every predicted command has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (cmds_pending != 0);
	endtask

	// all goals and the duration, written only with the block idle
	task automatic write_settings(input joint_vec_t goals, input logic [31:0] dur);
		drain();
		for (int r = 0; r <= FIELD_JOINTS; r++) begin
			cfg_wr_en <= 1'b1;
			if (r == FIELD_JOINTS) begin
				cfg_addr <= REG_DURATION;
				cfg_data <= dur;
			end else begin
				cfg_addr <= REG_GOAL_J1 + REG_IDX_W'(r);
				cfg_data <= {{16{goals[r][15]}}, goals[r]};
			end
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		joint_vec_t goals;
		logic       start;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		// the first tick after reset captures even without begin_req
		send_tick(16'd0, 1'b0, edge_refs(0));
		send_tick(16'hFFFF, 1'b0, random_refs());
		send_tick(16'hFFFF, 1'b1, edge_refs(1));
		send_tick(16'd1, 1'b0, random_refs());

		// goals at upper bounds and duration cut below elapsed, both mid-motion
		for (int j = 0; j < FIELD_JOINTS; j++)
			goals[j] = LIM_MAX[j];
		write_settings(goals, 32'd1);
		send_tick(16'd0, 1'b0, random_refs());
		send_tick(16'd7, 1'b0, random_refs());

		// goals at lower bounds, zero duration is complete at once
		for (int j = 0; j < FIELD_JOINTS; j++)
			goals[j] = LIM_MIN[j];
		write_settings(goals, 32'd0);
		send_tick(16'd5, 1'b1, random_refs());
		send_tick(16'd3, 1'b0, random_refs());

		// limit fault on each joint; joint 7 bad too so the lowest index must win
		for (int k = 0; k < FIELD_JOINTS; k++) begin
			goals = mid_goals();
			goals[k] = (k % 2) ? 16'h7FFF : 16'h8000;
			if (k < FIELD_JOINTS - 1)
				goals[FIELD_JOINTS - 1] = 16'h7FFF;
			write_settings(goals, 32'hFFFFFFFF);
			send_tick(16'($urandom), 1'b1, random_refs());
			// fault holds on a following tick without begin
			if (k == 3)
				send_tick(16'hFFFF, 1'b0, random_refs());
		end

		// legal goals, longest duration
		write_settings(mid_goals(), 32'hFFFFFFFF);
		send_tick(16'hFFFF, 1'b1, random_refs());
		send_tick(16'hFFFF, 1'b0, random_refs());

		// random part: receiver idling more first, then sender, then no idling
		for (int regime = 0; regime < 3; regime++) begin
			send_idle_pct = (regime == 0) ? 30 : (regime == 1) ? 55 : 0;
			recv_idle_pct <= (regime == 0) ? 55 : (regime == 1) ? 30 : 0;
			for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
				// one phase per regime tries out-of-range goals
				write_settings(random_goals((ph == 2) ? 30 : 0), random_duration());
				for (int n = 0; n < TICKS_PER_PHASE; n++) begin
					// phases 1 and 4 carry on the previous motion under new settings
					start = (n == 0 && ph != 1 && ph != 4) || ($urandom_range(99) < 6);
					send_tick(16'($urandom), start, random_refs());
					if ($urandom_range(99) < 3)
						drain();
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
